@@ rtl/hsvrgb_pkg.sv @@
package hsvrgb_pkg;

    localparam int unsigned HUE_W         = 15;
    localparam int unsigned CH_W          = 8;
    localparam int unsigned HUE_FRAC_BITS = 6;
    localparam int unsigned CHANNEL_BITS  = 8;
    localparam int unsigned SECTOR_DEG    = 60;
    localparam int unsigned SECTOR_UNITS  = SECTOR_DEG << HUE_FRAC_BITS;
    localparam int unsigned FRAC_ONE      = 256;
    localparam int unsigned SECTOR_HI     = SECTOR_UNITS / FRAC_ONE;
    localparam int unsigned CMAX          = (1 << CHANNEL_BITS) - 1;
    localparam int unsigned FULL_SCALE    = CMAX * FRAC_ONE;

    // reciprocal multipliers, exact over the operand ranges used
    localparam int unsigned RECIP_HI      = 137;    // x / 15 for x < 128, shift 11
    localparam int unsigned RECIP_HI_SH   = 11;
    localparam int unsigned RECIP_LO      = 34953;  // x / 15 for x < 3840, shift 19
    localparam int unsigned RECIP_LO_SH   = 19;
    localparam int unsigned RECIP_CM      = 32897;  // x / 255 for x < 65536, shift 23
    localparam int unsigned RECIP_CM_SH   = 23;

    localparam logic [3:0] SEC_RED_YEL = 4'd0;
    localparam logic [3:0] SEC_YEL_GRN = 4'd1;
    localparam logic [3:0] SEC_GRN_CYN = 4'd2;
    localparam logic [3:0] SEC_CYN_BLU = 4'd3;
    localparam logic [3:0] SEC_BLU_MAG = 4'd4;

    typedef struct packed {
        logic [3:0]      sector;
        logic [11:0]     rem;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] bri;
    } t_sec_req;

    typedef struct packed {
        logic [3:0]      sector;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] bri;
        logic [15:0]     sf;
        logic [15:0]     sfc;
        logic [15:0]     pv;
    } t_mix_req;

    typedef struct packed {
        logic [3:0]      sector;
        logic [CH_W-1:0] sat;
        logic [CH_W-1:0] bri;
        logic [CH_W-1:0] p;
        logic [CH_W-1:0] q;
        logic [CH_W-1:0] t;
    } t_pqt_req;

endpackage

@@ rtl/hsvrgb_sector.sv @@
module hsvrgb_sector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [hsvrgb_pkg::HUE_W-1:0]  i_hue,
    input  logic [hsvrgb_pkg::CH_W-1:0]   i_sat,
    input  logic [hsvrgb_pkg::CH_W-1:0]   i_bri,
    output logic                          o_valid,
    input  logic                          i_ready,
    output hsvrgb_pkg::t_sec_req          o_req
);

    logic                  r_vld;
    hsvrgb_pkg::t_sec_req  r_req;
    hsvrgb_pkg::t_sec_req  n_req;
    logic [7:0]            w_hi;
    logic [14:0]           w_prod;
    logic [3:0]            w_sec;
    logic [7:0]            w_mul;

    // hue = 256 * hi + lo, sector = hi / 15
    always_comb begin
        w_hi   = {1'b0, i_hue[14:8]};
        w_prod = 15'(w_hi) * 15'(hsvrgb_pkg::RECIP_HI);
        w_sec  = w_prod[hsvrgb_pkg::RECIP_HI_SH +: 4];
        w_mul  = 8'(w_sec) * 8'(hsvrgb_pkg::SECTOR_HI);
        n_req.sector = w_sec;
        n_req.rem    = {4'(w_hi - w_mul), i_hue[7:0]};
        n_req.sat    = i_sat;
        n_req.bri    = i_bri;
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= n_req;
        end
    end

    assign o_valid = r_vld;
    assign o_req   = r_req;

endmodule

@@ rtl/hsvrgb_mix.sv @@
module hsvrgb_mix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsvrgb_pkg::t_sec_req  i_req,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsvrgb_pkg::t_mix_req  o_req
);

    logic        r_vld2;
    logic        r_vld3;
    logic        w_rdy2;
    logic        w_rdy3;
    logic [3:0]  r_sector2;
    logic [7:0]  r_sat2;
    logic [7:0]  r_bri2;
    logic [7:0]  r_f8;
    logic [15:0] r_pv;
    logic [7:0]  n_f8;
    logic [15:0] n_pv;
    logic [27:0] w_f8_prod;
    logic [16:0] w_sfc;
    hsvrgb_pkg::t_mix_req r_req3;
    hsvrgb_pkg::t_mix_req n_req3;

    always_comb begin
        w_f8_prod = 28'(i_req.rem) * 28'(hsvrgb_pkg::RECIP_LO);
        n_f8      = w_f8_prod[hsvrgb_pkg::RECIP_LO_SH +: 8];
        n_pv      = 16'(i_req.bri) * 16'(8'(hsvrgb_pkg::CMAX) - i_req.sat);
    end

    always_comb begin
        w_sfc         = 17'(r_sat2) * (17'(hsvrgb_pkg::FRAC_ONE) - 17'(r_f8));
        n_req3.sector = r_sector2;
        n_req3.sat    = r_sat2;
        n_req3.bri    = r_bri2;
        n_req3.sf     = 16'(r_sat2) * 16'(r_f8);
        n_req3.sfc    = w_sfc[15:0];
        n_req3.pv     = r_pv;
    end

    assign w_rdy3  = !r_vld3 || i_ready;
    assign w_rdy2  = !r_vld2 || w_rdy3;
    assign o_ready = w_rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (w_rdy2) begin
                r_vld2 <= i_valid;
            end
            if (w_rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && i_valid) begin
            r_sector2 <= i_req.sector;
            r_sat2    <= i_req.sat;
            r_bri2    <= i_req.bri;
            r_f8      <= n_f8;
            r_pv      <= n_pv;
        end
        if (w_rdy3 && r_vld2) begin
            r_req3 <= n_req3;
        end
    end

    assign o_valid = r_vld3;
    assign o_req   = r_req3;

endmodule

@@ rtl/hsvrgb_scale.sv @@
module hsvrgb_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  hsvrgb_pkg::t_mix_req  i_req,
    output logic                  o_valid,
    input  logic                  i_ready,
    output hsvrgb_pkg::t_pqt_req  o_req
);

    logic        r_vld4;
    logic        r_vld5;
    logic        w_rdy4;
    logic        w_rdy5;
    logic [3:0]  r_sector4;
    logic [7:0]  r_sat4;
    logic [7:0]  r_bri4;
    logic [7:0]  r_p4;
    logic [23:0] r_qn;
    logic [23:0] r_tn;
    logic [31:0] w_p_prod;
    logic [31:0] w_q_prod;
    logic [31:0] w_t_prod;
    hsvrgb_pkg::t_pqt_req r_req5;
    hsvrgb_pkg::t_pqt_req n_req5;

    assign w_p_prod = 32'(i_req.pv) * 32'(hsvrgb_pkg::RECIP_CM);

    // divide by 255*256: drop the low byte, then divide by 255
    always_comb begin
        w_q_prod      = 32'(r_qn[23:8]) * 32'(hsvrgb_pkg::RECIP_CM);
        w_t_prod      = 32'(r_tn[23:8]) * 32'(hsvrgb_pkg::RECIP_CM);
        n_req5.sector = r_sector4;
        n_req5.sat    = r_sat4;
        n_req5.bri    = r_bri4;
        n_req5.p      = r_p4;
        n_req5.q      = w_q_prod[hsvrgb_pkg::RECIP_CM_SH +: 8];
        n_req5.t      = w_t_prod[hsvrgb_pkg::RECIP_CM_SH +: 8];
    end

    assign w_rdy5  = !r_vld5 || i_ready;
    assign w_rdy4  = !r_vld4 || w_rdy5;
    assign o_ready = w_rdy4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else begin
            if (w_rdy4) begin
                r_vld4 <= i_valid;
            end
            if (w_rdy5) begin
                r_vld5 <= r_vld4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && i_valid) begin
            r_sector4 <= i_req.sector;
            r_sat4    <= i_req.sat;
            r_bri4    <= i_req.bri;
            r_p4      <= w_p_prod[hsvrgb_pkg::RECIP_CM_SH +: 8];
            r_qn      <= 24'(i_req.bri) * (24'(hsvrgb_pkg::FULL_SCALE) - 24'(i_req.sf));
            r_tn      <= 24'(i_req.bri) * (24'(hsvrgb_pkg::FULL_SCALE) - 24'(i_req.sfc));
        end
        if (w_rdy5 && r_vld4) begin
            r_req5 <= n_req5;
        end
    end

    assign o_valid = r_vld5;
    assign o_req   = r_req5;

endmodule

@@ rtl/hsv_to_rgb_converter_core.sv @@
// path: an accepted request is registered in the sector, mix, scale and output stages before m_axis
// throughput: one pixel per cycle while m_axis_tready stays high, six register stages with a ready chain
// the chain lets a stalled output hold while empty stages keep filling
// reset: synchronous active-low i_rst_n clears every stage valid bit
// pixel data registers are not reset
module hsv_to_rgb_converter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[14:0], saturation[22:15], brightness[30:23]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic                 w_sec_vld;
    logic                 w_sec_rdy;
    logic                 w_mix_vld;
    logic                 w_mix_rdy;
    logic                 w_pqt_vld;
    logic                 w_rdy6;
    hsvrgb_pkg::t_sec_req w_sec;
    hsvrgb_pkg::t_mix_req w_mix;
    hsvrgb_pkg::t_pqt_req w_pqt;
    logic                 r_vld6;
    logic [7:0]           r_red;
    logic [7:0]           r_green;
    logic [7:0]           r_blue;
    logic [7:0]           n_red;
    logic [7:0]           n_green;
    logic [7:0]           n_blue;

    hsvrgb_sector u_sector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_hue   (s_axis_tdata[14:0]),
        .i_sat   (s_axis_tdata[22:15]),
        .i_bri   (s_axis_tdata[30:23]),
        .o_valid (w_sec_vld),
        .i_ready (w_sec_rdy),
        .o_req   (w_sec)
    );

    hsvrgb_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sec_vld),
        .o_ready (w_sec_rdy),
        .i_req   (w_sec),
        .o_valid (w_mix_vld),
        .i_ready (w_mix_rdy),
        .o_req   (w_mix)
    );

    hsvrgb_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mix_vld),
        .o_ready (w_mix_rdy),
        .i_req   (w_mix),
        .o_valid (w_pqt_vld),
        .i_ready (w_rdy6),
        .o_req   (w_pqt)
    );

    always_comb begin
        if (w_pqt.sat == '0) begin
            n_red   = w_pqt.bri;
            n_green = w_pqt.bri;
            n_blue  = w_pqt.bri;
        end else begin
            unique case (w_pqt.sector)
                hsvrgb_pkg::SEC_RED_YEL: begin
                    n_red = w_pqt.bri; n_green = w_pqt.t;   n_blue = w_pqt.p;
                end
                hsvrgb_pkg::SEC_YEL_GRN: begin
                    n_red = w_pqt.q;   n_green = w_pqt.bri; n_blue = w_pqt.p;
                end
                hsvrgb_pkg::SEC_GRN_CYN: begin
                    n_red = w_pqt.p;   n_green = w_pqt.bri; n_blue = w_pqt.t;
                end
                hsvrgb_pkg::SEC_CYN_BLU: begin
                    n_red = w_pqt.p;   n_green = w_pqt.q;   n_blue = w_pqt.bri;
                end
                hsvrgb_pkg::SEC_BLU_MAG: begin
                    n_red = w_pqt.t;   n_green = w_pqt.p;   n_blue = w_pqt.bri;
                end
                default: begin
                    n_red = w_pqt.bri; n_green = w_pqt.p;   n_blue = w_pqt.q;
                end
            endcase
        end
    end

    assign w_rdy6 = !r_vld6 || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld6 <= 1'b0;
        end else if (w_rdy6) begin
            r_vld6 <= w_pqt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy6 && w_pqt_vld) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign m_axis_tvalid = r_vld6;
    assign m_axis_tdata  = {r_blue, r_green, r_red};

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pqt_vld && w_rdy6 && w_pqt.sat == '0) |=>
        (r_red == r_green && r_green == r_blue))
        else $error("zero saturation not grey");

    a_first_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pqt_vld && w_rdy6 && w_pqt.sector == hsvrgb_pkg::SEC_RED_YEL) |=>
        (r_red == $past(w_pqt.bri)))
        else $error("red not at brightness in first sector");

    a_terms_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pqt_vld |-> (w_pqt.p <= w_pqt.bri && w_pqt.q <= w_pqt.bri &&
                       w_pqt.t <= w_pqt.bri))
        else $error("p, q or t above brightness");

endmodule

@@ test/hsv_to_rgb_converter_core_tb.sv @@
`timescale 1ns / 100ps

module hsv_to_rgb_converter_core_tb;

    typedef struct packed {
        logic [hsvrgb_pkg::CH_W-1:0] blue;
        logic [hsvrgb_pkg::CH_W-1:0] green;
        logic [hsvrgb_pkg::CH_W-1:0] red;
    } t_rgb;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // hue[14:0], saturation[22:15], brightness[30:23]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]

    t_rgb        pending_rgb[$];
    int unsigned pixels_sent    = 0;
    int unsigned pixels_checked = 0;
    int unsigned mismatches     = 0;
    int unsigned grey_pixels    = 0;
    int unsigned wrapped_pixels = 0;
    int unsigned src_idle_max   = 12;
    int unsigned snk_idle_max   = 12;

    hsv_to_rgb_converter_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_rgb hsv_to_rgb(input logic [hsvrgb_pkg::HUE_W-1:0] hue,
                                        input logic [hsvrgb_pkg::CH_W-1:0] sat,
                                        input logic [hsvrgb_pkg::CH_W-1:0] bri);
        int unsigned h;
        int unsigned s;
        int unsigned v;
        int unsigned sec;
        int unsigned f8;
        int unsigned p;
        int unsigned q;
        int unsigned t;
        t_rgb        c;
        h = hue;
        s = sat;
        v = bri;
        if (s == 0) begin
            c.red   = bri;
            c.green = bri;
            c.blue  = bri;
        end else begin
            sec = h / hsvrgb_pkg::SECTOR_UNITS;
            f8  = ((h % hsvrgb_pkg::SECTOR_UNITS) * hsvrgb_pkg::FRAC_ONE)
                  / hsvrgb_pkg::SECTOR_UNITS;
            p   = (v * (hsvrgb_pkg::CMAX - s)) / hsvrgb_pkg::CMAX;
            q   = (v * (hsvrgb_pkg::FULL_SCALE - s * f8)) / hsvrgb_pkg::FULL_SCALE;
            t   = (v * (hsvrgb_pkg::FULL_SCALE - s * (hsvrgb_pkg::FRAC_ONE - f8)))
                  / hsvrgb_pkg::FULL_SCALE;
            case (sec)
                hsvrgb_pkg::SEC_RED_YEL: begin
                    c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
                end
                hsvrgb_pkg::SEC_YEL_GRN: begin
                    c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
                end
                hsvrgb_pkg::SEC_GRN_CYN: begin
                    c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
                end
                hsvrgb_pkg::SEC_CYN_BLU: begin
                    c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
                end
                hsvrgb_pkg::SEC_BLU_MAG: begin
                    c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
                end
                // last arm also takes hue at or beyond 360 degrees
                default: begin
                    c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
                end
            endcase
        end
        return c;
    endfunction

    task automatic send_pixel(input logic [hsvrgb_pkg::HUE_W-1:0] hue,
                              input logic [hsvrgb_pkg::CH_W-1:0] sat,
                              input logic [hsvrgb_pkg::CH_W-1:0] bri);
        int unsigned gap;
        gap = $urandom_range(0, src_idle_max);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {1'b0, bri, sat, hue};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_rgb.push_back(hsv_to_rgb(hue, sat, bri));
        pixels_sent++;
        if (sat == 0) grey_pixels++;
        if (hue >= 6 * hsvrgb_pkg::SECTOR_UNITS) wrapped_pixels++;
    endtask

    // output side back-pressure, one draw per result
    initial begin
        int unsigned gap;
        forever begin
            @(negedge i_clk);
            gap = $urandom_range(0, snk_idle_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    function automatic void note_mismatch(input string what, input t_rgb exp_c,
                                          input t_rgb got_c);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0d (%s): expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     mismatches, what, exp_c.red, exp_c.green, exp_c.blue,
                     got_c.red, got_c.green, got_c.blue);
    endfunction

    always @(posedge i_clk) begin
        t_rgb got_c;
        t_rgb exp_c;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_c = m_axis_tdata;
            if (pending_rgb.size() == 0) begin
                note_mismatch("no request pending", '0, got_c);
            end else begin
                exp_c = pending_rgb.pop_front();
                pixels_checked++;
                if (got_c.red !== exp_c.red || got_c.green !== exp_c.green
                    || got_c.blue !== exp_c.blue)
                    note_mismatch("pixel", exp_c, got_c);
            end
        end
    end

    task automatic test_grey;
        send_pixel(15'd0, 8'd0, 8'd0);
        send_pixel(15'd0, 8'd0, 8'd255);
        send_pixel(15'd11520, 8'd0, 8'd128);
        send_pixel(15'd23039, 8'd0, 8'd1);
        send_pixel(15'd32767, 8'd0, 8'd254);
    endtask

    task automatic test_sectors;
        for (int unsigned k = 0; k < 6; k++) begin
            send_pixel(15'(k * hsvrgb_pkg::SECTOR_UNITS), 8'd255, 8'd255);
            send_pixel(15'(k * hsvrgb_pkg::SECTOR_UNITS + hsvrgb_pkg::SECTOR_UNITS / 2),
                       8'd200, 8'd170);
        end
        send_pixel(15'(hsvrgb_pkg::SECTOR_UNITS - 1), 8'd255, 8'd255);
        send_pixel(15'(6 * hsvrgb_pkg::SECTOR_UNITS - 1), 8'd1, 8'd255);
    endtask

    task automatic test_field_extremes;
        send_pixel(15'd0, 8'd255, 8'd0);
        send_pixel(15'd0, 8'd1, 8'd1);
        send_pixel(15'd23039, 8'd255, 8'd255);
        send_pixel(15'd16384, 8'd255, 8'd128);
    endtask

    task automatic test_wrapped_hue;
        send_pixel(15'(6 * hsvrgb_pkg::SECTOR_UNITS), 8'd255, 8'd255);
        send_pixel(15'd27000, 8'd128, 8'd200);
        send_pixel(15'd32767, 8'd255, 8'd255);
        send_pixel(15'd30719, 8'd77, 8'd33);
    endtask

    task automatic test_random(input int unsigned count);
        logic [hsvrgb_pkg::HUE_W-1:0] hue;
        logic [hsvrgb_pkg::CH_W-1:0]  sat;
        logic [hsvrgb_pkg::CH_W-1:0]  bri;
        int unsigned                  pick;
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 75 == 0) begin
                src_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
                snk_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
            end
            pick = $urandom_range(0, 19);
            if (pick < 2)
                hue = 15'($urandom_range(6 * hsvrgb_pkg::SECTOR_UNITS,
                                         (1 << hsvrgb_pkg::HUE_W) - 1));
            else if (pick < 5)
                hue = 15'($urandom_range(0, 5) * hsvrgb_pkg::SECTOR_UNITS
                          + $urandom_range(0, 1) * (hsvrgb_pkg::SECTOR_UNITS - 1));
            else
                hue = 15'($urandom_range(0, 6 * hsvrgb_pkg::SECTOR_UNITS - 1));
            pick = $urandom_range(0, 15);
            if (pick == 0)      sat = '0;
            else if (pick == 1) sat = 8'(hsvrgb_pkg::CMAX);
            else                sat = 8'($urandom);
            pick = $urandom_range(0, 15);
            if (pick == 0)      bri = '0;
            else if (pick == 1) bri = 8'(hsvrgb_pkg::CMAX);
            else                bri = 8'($urandom);
            send_pixel(hue, sat, bri);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_grey;
        test_sectors;
        test_field_extremes;
        test_wrapped_hue;
        test_random(1050);

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("sent %0d pixels (%0d grey, %0d with hue past 360 deg), checked %0d results",
                 pixels_sent, grey_pixels, wrapped_pixels, pixels_checked);
        $display("all six sectors, boundaries and field extremes under random stalls, %0d %s",
                 mismatches, "mismatches");
        if (mismatches == 0 && pending_rgb.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ hsv_to_rgb_converter_core.f @@
rtl/hsvrgb_pkg.sv
rtl/hsvrgb_sector.sv
rtl/hsvrgb_mix.sv
rtl/hsvrgb_scale.sv
rtl/hsv_to_rgb_converter_core.sv
test/hsv_to_rgb_converter_core_tb.sv
